// File: hw/rtl/uniform_scalar_quantizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the uniform scalar quantizer
// Implication and history checks; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef UNIFORM_SCALAR_QUANTIZER_ASSERT_SVH
`define UNIFORM_SCALAR_QUANTIZER_ASSERT_SVH

`ifndef SYNTH
`define USQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("usq: implication check failed");
`define USQ_ASSERT_PAST(label, clk, rst, cons, ante, depth) \
  label: assert property (@(posedge clk) disable iff (rst) (cons) |-> $past((ante), depth)) \
    else $error("usq: history check failed");
`else
`define USQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define USQ_ASSERT_PAST(label, clk, rst, cons, ante, depth)
`endif

`endif

// File: hw/rtl/usq_pkg.sv
// ----------------------------------------------------------------------------
// usq_pkg
// Types, constants and the divider step shared by the quantizer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package usq_pkg;

  localparam int VALUE_BITS = 8;
  localparam int STEPS_BITS = VALUE_BITS + 1;
  localparam int DIV_STAGES = (VALUE_BITS + 1) / 2;
  localparam int DIV_PAD    = 2 * DIV_STAGES;
  // front stage, two dividers, three back stages
  localparam int LATENCY    = 1 + 2 * DIV_STAGES + 3;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [STEPS_BITS-1:0] steps_t;
  typedef logic [1:0]            cfg_index_t;

  localparam cfg_index_t REG_VALUE_MIN = 2'd0;
  localparam cfg_index_t REG_VALUE_MAX = 2'd1;
  localparam cfg_index_t REG_NUM_STEPS = 2'd2;

  localparam value_t VALUE_MIN_RESET = '0;
  localparam value_t VALUE_MAX_RESET = '1;
  localparam steps_t NUM_STEPS_RESET = STEPS_BITS'(2);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_CONFIG = 2'd2
  } status_t;

  typedef struct packed {
    status_t status;
    value_t  vmin;
    value_t  d;
    steps_t  steps;
    value_t  step;
  } item_t;

  typedef struct packed {
    steps_t     rem;
    logic [1:0] q;
  } div_res_t;

  // Two restoring division steps: shift in two dividend bits, subtract where it fits.
  function automatic div_res_t div_step2(steps_t rem, logic [1:0] bits, steps_t dvs);
    logic [STEPS_BITS:0] trial;
    steps_t              r;
    div_res_t            res;
    r = rem;
    res.q = '0;
    for (int i = 1; i >= 0; i--) begin
      trial = {r, bits[i]};
      if (trial >= {1'b0, dvs}) begin
        trial = trial - {1'b0, dvs};
        res.q[i] = 1'b1;
      end
      r = trial[STEPS_BITS-1:0];
    end
    res.rem = r;
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/usq_front.sv
// ----------------------------------------------------------------------------
// usq_front
// Entry stage: range and configuration checks, offset and span.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usq_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  usq_pkg::value_t sample_value,
  input  usq_pkg::value_t value_min,
  input  usq_pkg::value_t value_max,
  input  usq_pkg::steps_t num_steps,
  output logic           out_valid,
  output usq_pkg::item_t out_item,
  output usq_pkg::value_t span
);
  import usq_pkg::*;

  status_t status_next;

  always_comb begin
    if ((value_min > value_max) || (num_steps < STEPS_BITS'(2))) begin
      status_next = ST_CONFIG;
    end else if ((sample_value < value_min) || (sample_value > value_max)) begin
      status_next = ST_RANGE;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item.status <= status_next;
    out_item.vmin   <= value_min;
    out_item.d      <= sample_value - value_min;
    out_item.steps  <= num_steps;
    out_item.step   <= '0;
    span            <= value_max - value_min;
  end

endmodule

`default_nettype wire

// File: hw/rtl/usq_div.sv
// ----------------------------------------------------------------------------
// usq_div
// Pipelined restoring divider, two quotient bits per stage, word alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "uniform_scalar_quantizer_assert.svh"

module usq_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  usq_pkg::item_t  in_item,
  input  usq_pkg::value_t dividend,
  input  usq_pkg::steps_t divisor,
  output logic            out_valid,
  output usq_pkg::item_t  out_item,
  output usq_pkg::value_t quotient
);
  import usq_pkg::*;

  logic               vld [DIV_STAGES+1];
  item_t              itm [DIV_STAGES+1];
  steps_t             rem [DIV_STAGES+1];
  steps_t             dvs [DIV_STAGES+1];
  logic [DIV_PAD-1:0] num [DIV_STAGES+1];
  logic [DIV_PAD-1:0] quo [DIV_STAGES+1];
  div_res_t           res [DIV_STAGES];

  assign vld[0] = in_valid;
  assign itm[0] = in_item;
  assign rem[0] = '0;
  assign dvs[0] = divisor;
  assign num[0] = DIV_PAD'(dividend);
  assign quo[0] = '0;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    assign res[k] = div_step2(rem[k], num[k][DIV_PAD-1 -: 2], dvs[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      itm[k+1] <= itm[k];
      dvs[k+1] <= dvs[k];
      rem[k+1] <= res[k].rem;
      num[k+1] <= num[k] << 2;
      quo[k+1] <= {quo[k][DIV_PAD-3:0], res[k].q};
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign out_item  = itm[DIV_STAGES];
  assign quotient  = quo[DIV_STAGES][VALUE_BITS-1:0];

  `USQ_ASSERT_PAST(a_div_no_invent, clk, rst, out_valid, in_valid, DIV_STAGES)
  `USQ_ASSERT_IMP(a_div_divisor_kept, clk, rst, out_valid, dvs[DIV_STAGES] == $past(divisor, DIV_STAGES))

endmodule

`default_nettype wire

// File: hw/rtl/usq_back.sv
// ----------------------------------------------------------------------------
// usq_back
// Index selection and capping, product, reconstruction and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "uniform_scalar_quantizer_assert.svh"

module usq_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  usq_pkg::item_t  in_item,
  input  usq_pkg::value_t quotient,
  output logic            done,
  output usq_pkg::value_t quant_index,
  output usq_pkg::value_t recon_value,
  output usq_pkg::status_t status
);
  import usq_pkg::*;

  value_t                idx_raw;
  value_t                idx_next;
  steps_t                last;
  steps_t                half_wide;
  logic [2*VALUE_BITS:0] sum;

  // stage 1
  logic    vld1;
  item_t   itm1;
  value_t  idx1;
  // stage 2
  logic                    vld2;
  status_t                 st2;
  value_t                  vmin2;
  value_t                  idx2;
  value_t                  half2;
  logic [2*VALUE_BITS-1:0] prod2;

  always_comb begin
    if (in_item.step != '0) begin
      idx_raw = (in_item.d == '0) ? '0 : quotient;
    end else begin
      idx_raw = in_item.d;
    end
    last = in_item.steps - STEPS_BITS'(1);
    // cap at the last interval
    if (STEPS_BITS'(idx_raw) > last) begin
      idx_next = last[VALUE_BITS-1:0];
    end else begin
      idx_next = idx_raw;
    end
  end

  assign half_wide = (STEPS_BITS'(itm1.step) + STEPS_BITS'(1)) >> 1;
  assign sum = (2*VALUE_BITS+1)'(vmin2) + (2*VALUE_BITS+1)'(prod2)
             + (2*VALUE_BITS+1)'(half2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      done <= 1'b0;
    end else begin
      vld1 <= in_valid;
      vld2 <= vld1;
      done <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    itm1  <= in_item;
    idx1  <= idx_next;
    st2   <= itm1.status;
    vmin2 <= itm1.vmin;
    idx2  <= idx1;
    half2 <= half_wide[VALUE_BITS-1:0];
    prod2 <= idx1 * itm1.step;
    status <= st2;
    if (st2 == ST_OK) begin
      quant_index <= idx2;
      recon_value <= sum[VALUE_BITS-1:0];
    end else begin
      quant_index <= '0;
      recon_value <= '0;
    end
  end

  `USQ_ASSERT_IMP(a_back_index_capped, clk, rst, vld1 && (itm1.status == ST_OK), STEPS_BITS'(idx1) < itm1.steps)

endmodule

`default_nettype wire

// File: hw/rtl/uniform_scalar_quantizer.sv
// ----------------------------------------------------------------------------
// uniform_scalar_quantizer
// Maps a sample onto an interval index and reconstruction value.
// ----------------------------------------------------------------------------
//  channel   ports                                      handshake
//  input     sample_value                               start & !busy
//  result    quant_index, recon_value, status           done strobe, one cycle
//  config    cfg_index, cfg_data                        cfg_write
//
//  One sample per cycle; each result passes from the entry stage through the
//  two pipelined dividers (step, then index), at two quotient bits per stage,
//  and then through the three reconstruction stages.
//  busy is high only during reset. Reset clears the valid bits and loads
//  the register defaults. The receiver cannot stall, so the pipeline always
//  advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "uniform_scalar_quantizer_assert.svh"

module uniform_scalar_quantizer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  usq_pkg::value_t      sample_value,
  output logic                 done,
  output usq_pkg::value_t      quant_index,
  output usq_pkg::value_t      recon_value,
  output logic [1:0]           status,
  input  logic                 cfg_write,
  input  usq_pkg::cfg_index_t  cfg_index,
  input  usq_pkg::steps_t      cfg_data
);
  import usq_pkg::*;

  value_t  value_min;
  value_t  value_max;
  steps_t  num_steps;

  logic    accept;
  logic    f_valid;
  item_t   f_item;
  value_t  f_span;
  logic    d1_valid;
  item_t   d1_item;
  item_t   mid_item;
  value_t  d1_quo;
  logic    d2_valid;
  item_t   d2_item;
  value_t  d2_quo;
  status_t st_out;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_min <= VALUE_MIN_RESET;
      value_max <= VALUE_MAX_RESET;
      num_steps <= NUM_STEPS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VALUE_MIN: value_min <= cfg_data[VALUE_BITS-1:0];
        REG_VALUE_MAX: value_max <= cfg_data[VALUE_BITS-1:0];
        REG_NUM_STEPS: num_steps <= cfg_data;
        default: ;
      endcase
    end
  end

  usq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .sample_value (sample_value),
    .value_min    (value_min),
    .value_max    (value_max),
    .num_steps    (num_steps),
    .out_valid    (f_valid),
    .out_item     (f_item),
    .span         (f_span)
  );

  // step = span / num_steps
  usq_div u_div_step (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .dividend  (f_span),
    .divisor   (f_item.steps),
    .out_valid (d1_valid),
    .out_item  (d1_item),
    .quotient  (d1_quo)
  );

  always_comb begin
    mid_item      = d1_item;
    mid_item.step = d1_quo;
  end

  // index = (d - 1) / step; zero offset and zero step are fixed up behind
  usq_div u_div_index (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d1_valid),
    .in_item   (mid_item),
    .dividend  (mid_item.d - VALUE_BITS'(1)),
    .divisor   (STEPS_BITS'(d1_quo)),
    .out_valid (d2_valid),
    .out_item  (d2_item),
    .quotient  (d2_quo)
  );

  usq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (d2_valid),
    .in_item     (d2_item),
    .quotient    (d2_quo),
    .done        (done),
    .quant_index (quant_index),
    .recon_value (recon_value),
    .status      (st_out)
  );

  assign status = st_out;

  `USQ_ASSERT_PAST(a_top_latency, clk, rst, done, accept, LATENCY)
  `USQ_ASSERT_IMP(a_top_bad_zeroed, clk, rst, done && (st_out != ST_OK), (quant_index == '0) && (recon_value == '0))

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: uniform scalar quantizer testbench
// Streams samples through the quantizer under a series of register settings
// and checks every index, reconstruction value and status word against a
// behavioural quantizer kept in step with the registers.
// ----------------------------------------------------------------------------

module tb_top;
  import usq_pkg::*;

  localparam cfg_index_t REG_UNUSED = 2'd3;
  localparam int RANDOM_PHASES   = 22;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int STALL_LIMIT     = 1000;

  typedef struct packed {
    value_t  quant_idx;
    value_t  recon;
    status_t code;
  } quant_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  value_t     sample_value = '0;
  logic       done;
  value_t     quant_index;
  value_t     recon_value;
  logic [1:0] status;
  logic       cfg_write = 1'b0;
  cfg_index_t cfg_index = REG_VALUE_MIN;
  steps_t     cfg_data = '0;

  // register copies seen by the predictor
  value_t cfg_lo    = VALUE_MIN_RESET;
  value_t cfg_hi    = VALUE_MAX_RESET;
  steps_t cfg_steps = NUM_STEPS_RESET;

  value_t      samples_to_send[$];
  quant_word_t expected_words[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  bit          steady = 1'b0;

  uniform_scalar_quantizer u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_value (sample_value),
    .done         (done),
    .quant_index  (quant_index),
    .recon_value  (recon_value),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic quant_word_t quantize(value_t x);
    int unsigned lo, hi, n, step, d, idx;
    quant_word_t w;
    lo = cfg_lo;
    hi = cfg_hi;
    n  = cfg_steps;
    w.quant_idx = '0;
    w.recon     = '0;
    w.code      = ST_OK;
    if (lo > hi || n < 2) begin
      w.code = ST_CONFIG;
    end else if (x < lo || x > hi) begin
      w.code = ST_RANGE;
    end else begin
      step = (hi - lo) / n;
      d    = x - lo;
      // with a zero step the index follows the offset, capped below
      if (step > 0) begin
        idx = (d == 0) ? 0 : (d - 1) / step;
      end else begin
        idx = d;
      end
      if (idx > n - 1) begin
        idx = n - 1;
      end
      w.quant_idx = value_t'(idx);
      w.recon     = value_t'(lo + idx * step + ((step + 1) >> 1));
    end
    return w;
  endfunction

  function automatic value_t random_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (cfg_lo > cfg_hi || pick < 20) begin
      return value_t'($urandom);
    end
    if (pick < 25) begin
      return cfg_lo;
    end
    if (pick < 30) begin
      return cfg_hi;
    end
    return value_t'($urandom_range(cfg_hi, cfg_lo));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic write_reg(cfg_index_t idx, steps_t data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_VALUE_MIN: cfg_lo = data[VALUE_BITS-1:0];
      REG_VALUE_MAX: cfg_hi = data[VALUE_BITS-1:0];
      REG_NUM_STEPS: cfg_steps = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic setup(steps_t lo_word, steps_t hi_word, steps_t steps);
    write_reg(REG_VALUE_MIN, lo_word);
    write_reg(REG_VALUE_MAX, hi_word);
    write_reg(REG_NUM_STEPS, steps);
    end_writes();
  endtask

  // hold until every sample is sent and answered, then let the pipe empty
  task automatic drain();
    while (samples_to_send.size() != 0 || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic random_config();
    int unsigned lo, hi, s;
    lo = $urandom_range(255);
    hi = $urandom_range(255, lo);
    s  = $urandom_range(256, 2);
    case ($urandom_range(11))
      6, 7: hi = $urandom_range((lo + 20 > 255) ? 255 : lo + 20, lo);
      8: begin
        lo = 0;
        hi = 255;
        s  = $urandom_range(1) ? 256 : 2;
      end
      9: s = $urandom_range(511, 257);
      10: s = $urandom_range(1, 0);
      11: begin
        lo = $urandom_range(255, 1);
        hi = $urandom_range(lo - 1, 0);
      end
      default: ;
    endcase
    if ($urandom_range(7) == 0) begin
      write_reg(REG_UNUSED, steps_t'($urandom));
    end
    write_reg(REG_VALUE_MIN, {1'($urandom_range(1)), value_t'(lo)});
    write_reg(REG_VALUE_MAX, {1'($urandom_range(1)), value_t'(hi)});
    write_reg(REG_NUM_STEPS, steps_t'(s));
    end_writes();
  endtask

  // driver: the word on the port stays at the head of the queue until taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_words.push_back(quantize(samples_to_send.pop_front()));
      end
      if (samples_to_send.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
        start        <= 1'b1;
        sample_value <= samples_to_send[0];
      end else begin
        start        <= 1'b0;
        sample_value <= value_t'($urandom);
      end
    end
  end

  always @(posedge clk) begin
    quant_word_t want;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected result index", quant_index, 0);
      end else begin
        want = expected_words.pop_front();
        if (quant_index !== want.quant_idx) begin
          report_mismatch("quant_index", quant_index, want.quant_idx);
        end
        if (recon_value !== want.recon) begin
          report_mismatch("recon_value", recon_value, want.recon);
        end
        if (status !== want.code) begin
          report_mismatch("status", status, want.code);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("uniform_scalar_quantizer test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: two intervals over the full range
    samples_to_send = '{8'd0, 8'd127, 8'd128, 8'd255};
    drain();

    // upper bit of the word is dropped on the bound registers
    setup(9'h10A, 9'h0C8, 9'd7);
    samples_to_send = '{8'd9, 8'd10, 8'd11, 8'd200, 8'd201};
    drain();

    // a write past the last register leaves the settings alone
    write_reg(REG_UNUSED, '1);
    end_writes();
    samples_to_send = '{8'd100};
    drain();

    // more intervals than values: zero step
    setup(9'd0, 9'd255, 9'd256);
    samples_to_send = '{8'd0, 8'd255};
    drain();
    setup(9'd0, 9'd255, 9'd511);
    samples_to_send = '{8'd200};
    drain();

    // invalid settings
    setup(9'd0, 9'd255, 9'd0);
    samples_to_send = '{8'd50};
    drain();
    setup(9'd0, 9'd255, 9'd1);
    samples_to_send = '{8'd50};
    drain();
    setup(9'd200, 9'd100, 9'd4);
    samples_to_send = '{8'd150, 8'd0};
    drain();

    // single-value range
    setup(9'd77, 9'd77, 9'd2);
    samples_to_send = '{8'd77, 8'd78};
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady = (p >= 8 && p < 11);
      random_config();
      repeat (ITEMS_PER_PHASE) samples_to_send.push_back(random_sample());
      drain();
    end

    if (mismatch_count == 0) begin
      $display("uniform_scalar_quantizer test passed");
    end else begin
      $display("uniform_scalar_quantizer test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/usq_pkg.sv
hw/rtl/usq_front.sv
hw/rtl/usq_div.sv
hw/rtl/usq_back.sv
hw/rtl/uniform_scalar_quantizer.sv
bench/tb_top.sv
